// ===== rtl/bpd_pkg.sv =====
package bpd_pkg;

  // Bank geometry.
  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS    = 16;

  // Fixed field widths of the request and result items.
  localparam int QID_FIELD_W = 5;
  localparam int TAG_FIELD_W = 16;
  localparam int CNT_FIELD_W = 4;

  // Stored tag width: tags are masked to TAG_BITS, and never exceed the field.
  localparam int STORE_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;

  // Queue index, slot pointer and occupancy widths.
  localparam int QID_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = QID_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  typedef enum logic [0:0] {
    ACT_ADD  = 1'b0,
    ACT_TAKE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_INVALID = 3'd2,
    ST_TAKEN   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    action_t                  action;
    logic [QID_FIELD_W-1:0]   queue_id;
    logic [TAG_FIELD_W-1:0]   entry_tag;
    logic                     urgent;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [TAG_FIELD_W-1:0]   out_tag;
    logic                     out_urgent;
    logic [CNT_FIELD_W-1:0]   queue_count;
  } out_item_t;

  // Entry storage access issued by the queue controller.
  typedef struct packed {
    logic                en;
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [STORE_W-1:0]  tag;
    logic                urgent;
  } mem_req_t;

  // Per-request outcome handed to the result stage.
  typedef struct packed {
    status_t                 status;
    logic                    take;
    logic [CNT_FIELD_W-1:0]  count;
  } res_t;

endpackage

// ===== rtl/bpd_store.sv =====
module bpd_store
  import bpd_pkg::*;
(
  input  logic                clk,
  input  logic                fire,
  input  mem_req_t            req,
  output logic [STORE_W-1:0]  rd_tag,
  output logic                rd_urgent
);

  typedef struct packed {
    logic [STORE_W-1:0] tag;
    logic               urgent;
  } entry_t;

  entry_t mem [MEM_DEPTH];
  entry_t rd_r;

  // Single port: one write or one read per request.
  always_ff @(posedge clk) begin
    if (fire && req.en) begin
      if (req.we) begin
        mem[req.addr] <= '{tag: req.tag, urgent: req.urgent};
      end else begin
        rd_r <= mem[req.addr];
      end
    end
  end

  assign rd_tag    = rd_r.tag;
  assign rd_urgent = rd_r.urgent;

endmodule

// ===== rtl/bpd_ctrl.sv =====
module bpd_ctrl
  import bpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output mem_req_t  req,
  output res_t      res
);

  // Each queue is a circular buffer: a head pointer and an occupancy count.
  logic [CNT_W-1:0] cnt_r  [NUM_QUEUES];
  logic [PTR_W-1:0] head_r [NUM_QUEUES];

  logic                   qid_ok;
  logic [QID_W-1:0]       q;
  logic [CNT_W-1:0]       n;
  logic [PTR_W-1:0]       h;
  logic [PTR_W-1:0]       h_dec;
  logic [PTR_W-1:0]       h_inc;
  logic [SUM_W-1:0]       tail_sum;
  logic [PTR_W-1:0]       tail;
  logic                   upd;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [PTR_W-1:0]       head_nxt;

  assign qid_ok = (item.queue_id != '0) &&
                  (item.queue_id <= QID_FIELD_W'(NUM_QUEUES));
  assign q      = QID_W'(item.queue_id - QID_FIELD_W'(1));

  always_comb begin
    n = '0;
    h = '0;
    if (qid_ok) begin
      n = cnt_r[q];
      h = head_r[q];
    end
  end

  assign h_dec    = (h == '0) ? PTR_W'(QUEUE_DEPTH - 1) : h - PTR_W'(1);
  assign h_inc    = (h == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : h + PTR_W'(1);
  assign tail_sum = SUM_W'(h) + SUM_W'(n);

  always_comb begin
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
  end

  always_comb begin
    req      = '0;
    res      = '{status: ST_INVALID, take: 1'b0, count: '0};
    upd      = 1'b0;
    cnt_nxt  = n;
    head_nxt = h;
    if (qid_ok) begin
      res.count = CNT_FIELD_W'(n);
      if (item.action == ACT_ADD) begin
        if (n >= CNT_W'(QUEUE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          // An urgent entry goes in front of the head, so nothing has to move.
          res.status = ST_ADDED;
          cnt_nxt    = n + CNT_W'(1);
          head_nxt   = item.urgent ? h_dec : h;
          upd        = 1'b1;
          res.count  = CNT_FIELD_W'(cnt_nxt);
          req.en     = 1'b1;
          req.we     = 1'b1;
          req.addr   = {q, (item.urgent ? h_dec : tail)};
          req.tag    = item.entry_tag[STORE_W-1:0];
          req.urgent = item.urgent;
        end
      end else begin
        if (n == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_TAKEN;
          res.take   = 1'b1;
          cnt_nxt    = n - CNT_W'(1);
          head_nxt   = h_inc;
          upd        = 1'b1;
          res.count  = CNT_FIELD_W'(cnt_nxt);
          req.en     = 1'b1;
          req.we     = 1'b0;
          req.addr   = {q, h};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else if (fire && upd) begin
      cnt_r[q]  <= cnt_nxt;
      head_r[q] <= head_nxt;
    end
  end

  a_add_count : assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.status == ST_ADDED) |=>
      cnt_r[$past(q)] == $past(res.count[CNT_W-1:0]))
    else $error("queue count not advanced after an add");

  a_no_access : assert property (@(posedge clk) disable iff (!rst_n)
    (res.status == ST_FULL) || (res.status == ST_EMPTY) ||
    (res.status == ST_INVALID) |-> !req.en && !upd)
    else $error("storage or queue state touched by a rejected request");

endmodule

// ===== rtl/banked_priority_deque.sv =====
// Bank of NUM_QUEUES bounded deques, QUEUE_DEPTH entries each.
//
// Input channel (in_valid / in_stall / in_data): one request per transfer.
// An add places entry_tag at the tail of queue queue_id, or at the head when
// urgent is set; a take pops the head. Queue numbers run from 1. Every
// request gives exactly one result on the output channel (out_valid /
// out_stall / out_data) carrying a status, the taken tag and mark, and the
// queue's occupancy after the request.
//
// A request sits in the input register, where the queue controller updates
// head pointer and count and issues one access to the single-port entry
// memory; the result register and the registered memory read data form the
// output on the next cycle. One request is taken per cycle while the output
// is not stalled, set by the one memory port each request uses. The result
// register lets a new request enter while a result waits.
//
// Reset clears every head pointer and count; the entry memory itself is not
// cleared, since only entries within a queue's occupancy are read.
// While out_stall is high with a result waiting, the request in the input
// register holds and in_stall rises; nothing is lost or repeated.
module banked_priority_deque
  import bpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  // Input register.
  logic      p1_valid_r;
  logic      p1_valid_nxt;
  in_item_t  in_r;

  // Result register.
  logic      p2_valid_r;
  logic      p2_valid_nxt;
  res_t      res_r;

  logic                p2_load;
  logic                fire;
  logic                in_xfer;
  mem_req_t            req;
  res_t                res;
  logic [STORE_W-1:0]  rd_tag;
  logic                rd_urgent;

  // The result register can load when empty or when its result transfers now.
  assign p2_load  = !p2_valid_r || !out_stall;
  assign fire     = p1_valid_r && p2_load;
  assign in_stall = p1_valid_r && !p2_load;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (in_xfer) begin
      p1_valid_nxt = 1'b1;
    end else if (fire) begin
      p1_valid_nxt = 1'b0;
    end
    p2_valid_nxt = p2_load ? fire : p2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
      p2_valid_r <= p2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  bpd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .req   (req),
    .res   (res)
  );

  // Read data is loaded on the same edge as the result register.
  bpd_store u_store (
    .clk       (clk),
    .fire      (fire),
    .req       (req),
    .rd_tag    (rd_tag),
    .rd_urgent (rd_urgent)
  );

  assign out_valid = p2_valid_r;

  always_comb begin
    out_data             = '0;
    out_data.status      = res_r.status;
    out_data.queue_count = res_r.count;
    if (res_r.take) begin
      out_data.out_tag    = TAG_FIELD_W'(rd_tag);
      out_data.out_urgent = rd_urgent;
    end
  end

  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed request produced no result");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> p1_valid_r && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
